// ===== rtl/shc_pkg.sv =====
// Package: types and constants shared by the strip hit clusterer
`timescale 1ns / 1ps
package shc_pkg;

    localparam int NUM_STRIPS = 1024;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE = 2'd2;

    localparam logic [10:0] COUNT_MAX = 11'h7FF;
    localparam logic [25:0] SUM26_MAX = 26'h3FFFFFF;
    localparam logic [36:0] SUM37_MAX = 37'h1FFFFFFFFF;
    localparam logic [17:0] CENT_MAX = 18'h3FFFF;
    localparam int DIV_STEPS = 45;

    typedef struct packed {
        logic        hit_valid;
        logic [1:0]  strip_type;
        logic [9:0]  strip_number;
        logic [15:0] amplitude;
        logic [15:0] hit_charge;
        logic [15:0] hit_time;
        logic        frame_end;
    } hit_t;

    typedef struct packed {
        logic [1:0]  cluster_type;
        logic [10:0] cluster_size;
        logic signed [11:0] strip_span;
        logic [25:0] total_amplitude;
        logic [15:0] peak_amplitude;
        logic [15:0] earliest_time;
        logic [17:0] centroid_q8;
        logic        last_of_item;
    } cluster_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_OUTPUT,
        ST_CLEAR
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_hit;    // latch the accepted beat
        logic close_grp;   // snapshot open cluster for reporting
        logic clear_grp;   // reset accumulators
        logic accum;       // add latched hit into the group
        logic div_start;
        logic div_step;
        logic out_load;
        logic out_last;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic brk;         // latched hit breaks the open cluster
        logic hit_valid;
        logic frame_end;
        logic open;
        logic size_ok;     // open cluster passes size window
        logic one_ok;      // a single-hit cluster passes size window
        logic div_done;
    } dp_stat_t;

endpackage

// ===== rtl/strip_hit_clusterer.sv =====
// Top level: strip hit clusterer with configuration registers
//
//  channel | dir | handshake           | payload
//  hit     | in  | in_valid/in_ready   | hit_t
//  cluster | out | out_valid/out_ready | cluster_t
//  cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// A hit passes through IDLE and ACCUM when it reports nothing, and through CLEAR as
// well with frame end; each reported cluster also passes through the close, the
// bit-serial centroid divider (45 quotient bits) and the output load.
// Reset clears control state and the cluster accumulators; no clearing pass.
// A stalled output holds the next report in the divider and blocks new hits.
`timescale 1ns / 1ps
module strip_hit_clusterer
    import shc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hit_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cluster_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [3:0]  max_gap_reg;
    logic [10:0] min_size_reg;
    logic [10:0] max_size_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg <= 4'd0;
            min_size_reg <= 11'd1;
            max_size_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_GAP:  max_gap_reg <= cfg_data[3:0];
                REG_MIN_SIZE: min_size_reg <= cfg_data;
                REG_MAX_SIZE: max_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    shc_controller u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .cmd(cmd)
    );

    shc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .hit(in_data),
        .max_gap(max_gap_reg), .min_size(min_size_reg), .max_size(max_size_reg),
        .cmd(cmd), .stat(stat), .result(out_data)
    );

endmodule

// ===== rtl/shc_datapath.sv =====
// Datapath: hit latch, cluster accumulators, serial centroid divider, output register
`timescale 1ns / 1ps
module shc_datapath
    import shc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hit_t        hit,
    input  logic [3:0]  max_gap,
    input  logic [10:0] min_size,
    input  logic [10:0] max_size,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output cluster_t    result
);

    hit_t        hit_reg;
    logic        open_reg;
    logic [1:0]  type_reg;
    logic [10:0] count_reg;
    logic [9:0]  first_reg;
    logic [9:0]  last_reg;
    logic [25:0] amp_sum_reg;
    logic [15:0] peak_reg;
    logic [15:0] tmin_reg;
    logic [25:0] wsum_reg;
    logic [36:0] moment_reg;
    logic [36:0] prod_reg;

    // snapshot of the closed cluster
    logic [1:0]  s_type_reg;
    logic [10:0] s_count_reg;
    logic [11:0] s_span_reg;
    logic [25:0] s_amp_reg;
    logic [15:0] s_peak_reg;
    logic [15:0] s_tmin_reg;
    logic [25:0] s_wsum_reg;

    // restoring divider: (moment << 8) / wsum, one quotient bit per cycle
    logic [44:0] dividend_reg;
    logic [26:0] rem_reg;
    logic [44:0] quot_reg;
    logic [5:0]  step_reg;

    cluster_t    out_reg;

    logic [11:0] reach;
    logic [11:0] amp_add;
    logic [26:0] amp_s;
    logic [26:0] w_s;
    logic [37:0] m_s;
    logic [26:0] rem_shift;
    logic [26:0] rem_sub;
    logic [17:0] cent;

    assign reach = {2'b0, last_reg} + 12'd1 + {8'b0, max_gap};
    assign amp_add = 12'd0;
    assign amp_s = {1'b0, amp_sum_reg} + {11'b0, hit_reg.amplitude};
    assign w_s = {1'b0, wsum_reg} + {11'b0, hit_reg.hit_charge};
    assign m_s = {1'b0, moment_reg} + {1'b0, prod_reg};
    assign rem_shift = {rem_reg[25:0], dividend_reg[44]};
    assign rem_sub = rem_shift - {1'b0, s_wsum_reg};

    always_comb
    begin
        if (s_wsum_reg == 26'd0)
            cent = 18'd0;
        else if (quot_reg[44:18] != 27'd0)
            cent = CENT_MAX;
        else
            cent = quot_reg[17:0];
    end

    assign stat.brk = open_reg && ((hit_reg.strip_type != type_reg) ||
                      ({2'b0, hit_reg.strip_number} > reach) || (amp_add != 12'd0));
    assign stat.hit_valid = hit_reg.hit_valid;
    assign stat.frame_end = hit_reg.frame_end;
    assign stat.open = open_reg;
    assign stat.size_ok = (count_reg >= min_size) && (count_reg <= max_size);
    assign stat.one_ok = (min_size <= 11'd1) && (max_size >= 11'd1);
    assign stat.div_done = (step_reg == 6'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            step_reg <= 6'd0;
        end
        else
        begin
            if (cmd.clear_grp)
                open_reg <= 1'b0;
            else if (cmd.accum)
                open_reg <= 1'b1;
            if (cmd.div_start)
                step_reg <= 6'(DIV_STEPS);
            else if (cmd.div_step && step_reg != 6'd0)
                step_reg <= step_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= 2'd0;
            count_reg <= 11'd0;
            first_reg <= 10'd0;
            last_reg <= 10'd0;
            amp_sum_reg <= 26'd0;
            peak_reg <= 16'd0;
            tmin_reg <= 16'hFFFF;
            wsum_reg <= 26'd0;
            moment_reg <= 37'd0;
        end
        else if (cmd.clear_grp)
        begin
            type_reg <= 2'd0;
            count_reg <= 11'd0;
            first_reg <= 10'd0;
            last_reg <= 10'd0;
            amp_sum_reg <= 26'd0;
            peak_reg <= 16'd0;
            tmin_reg <= 16'hFFFF;
            wsum_reg <= 26'd0;
            moment_reg <= 37'd0;
        end
        else if (cmd.accum)
        begin
            if (!open_reg)
            begin
                type_reg <= hit_reg.strip_type;
                first_reg <= hit_reg.strip_number;
            end
            last_reg <= hit_reg.strip_number;
            if (count_reg != COUNT_MAX)
                count_reg <= count_reg + 11'd1;
            amp_sum_reg <= amp_s[26] ? SUM26_MAX : amp_s[25:0];
            if (hit_reg.amplitude > peak_reg)
                peak_reg <= hit_reg.amplitude;
            if (hit_reg.hit_time < tmin_reg)
                tmin_reg <= hit_reg.hit_time;
            wsum_reg <= w_s[26] ? SUM26_MAX : w_s[25:0];
            moment_reg <= m_s[37] ? SUM37_MAX : m_s[36:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_hit)
        begin
            hit_reg <= hit;
            prod_reg <= {27'd0, hit.strip_number} * {21'd0, hit.hit_charge};
        end
        if (cmd.close_grp)
        begin
            s_type_reg <= type_reg;
            s_count_reg <= count_reg;
            s_span_reg <= {2'b0, last_reg} + 12'd1 - {2'b0, first_reg};
            s_amp_reg <= amp_sum_reg;
            s_peak_reg <= peak_reg;
            s_tmin_reg <= tmin_reg;
            s_wsum_reg <= wsum_reg;
            dividend_reg <= {moment_reg, 8'd0};
            rem_reg <= 27'd0;
            quot_reg <= 45'd0;
        end
        else if (cmd.div_step && step_reg != 6'd0)
        begin
            dividend_reg <= {dividend_reg[43:0], 1'b0};
            if (!rem_sub[26])
            begin
                rem_reg <= rem_sub;
                quot_reg <= {quot_reg[43:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quot_reg <= {quot_reg[43:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            out_reg.cluster_type <= s_type_reg;
            out_reg.cluster_size <= s_count_reg;
            out_reg.strip_span <= s_span_reg;
            out_reg.total_amplitude <= s_amp_reg;
            out_reg.peak_amplitude <= s_peak_reg;
            out_reg.earliest_time <= s_tmin_reg;
            out_reg.centroid_q8 <= cent;
            out_reg.last_of_item <= cmd.out_last;
        end
    end

    assign result = out_reg;

endmodule

// ===== rtl/shc_controller.sv =====
// Controller: sequences accept, break close, accumulate, flush and result delivery
`timescale 1ns / 1ps
module shc_controller
    import shc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   flush_reg, flush_next;     // current close is the frame flush
    logic   busy_reg, busy_next;       // output register holds a beat
    logic   pend_reg, pend_next;       // snapshot waiting in divider

    // flush follows a break close when frame_end is set
    logic more;
    assign more = !flush_reg && stat.frame_end && stat.hit_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flush_reg <= 1'b0;
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
            busy_reg <= busy_next;
            pend_reg <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        busy_next = busy_reg;
        pend_next = pend_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = busy_reg;
        if (busy_reg && out_ready)
            busy_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_hit = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (stat.hit_valid && stat.brk)
                begin
                    // close old cluster before taking the hit
                    cmd.close_grp = 1'b1;
                    cmd.clear_grp = 1'b1;
                    flush_next = 1'b0;
                    pend_next = stat.size_ok;
                    cmd.div_start = stat.size_ok;
                    state_next = stat.size_ok ? ST_DIVIDE : ST_ACCUM;
                end
                else
                begin
                    cmd.accum = stat.hit_valid;
                    state_next = stat.frame_end ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                flush_next = 1'b1;
                if (stat.open && stat.size_ok)
                begin
                    cmd.close_grp = 1'b1;
                    cmd.div_start = 1'b1;
                    pend_next = 1'b1;
                    state_next = ST_DIVIDE;
                end
                else
                    state_next = ST_IDLE;
                cmd.clear_grp = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (!busy_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    // a break close is last unless a flush still follows
                    cmd.out_last = flush_reg || !stat.frame_end || !stat.one_ok;
                    busy_next = 1'b1;
                    pend_next = 1'b0;
                    if (flush_reg)
                    begin
                        flush_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else if (more)
                        state_next = ST_ACCUM;
                    else
                        state_next = ST_ACCUM;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/shc_checker.sv =====
// Checker: port-level properties of the strip hit clusterer, bound to the top
`timescale 1ns / 1ps
module shc_checker
    import shc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input cluster_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("two hits accepted back to back");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.cluster_size != 11'd0)
        else $error("empty cluster reported");

endmodule

bind strip_hit_clusterer shc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== verif/tb_strip_hit_clusterer.sv =====
// Testbench for the strip hit clusterer: directed table, then random hit streams
`timescale 1ns / 1ps
module tb_strip_hit_clusterer;
    import shc_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    hit_t                  in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    cluster_t              out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    strip_hit_clusterer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // cluster reports still owed by the block, oldest first
    cluster_t pending_clusters[$];
    int       push_count = 0;
    int       err_count = 0;
    bit       tx_busy_mode = 1'b0;
    bit       rx_busy_mode = 1'b0;

    // shadow configuration and open-cluster state
    logic [3:0]  sh_max_gap;
    logic [10:0] sh_min_size;
    logic [10:0] sh_max_size;
    logic        grp_open;
    logic [1:0]  grp_type;
    logic [10:0] grp_count;
    logic [9:0]  grp_first;
    logic [9:0]  grp_last;
    logic [25:0] grp_amp_sum;
    logic [15:0] grp_amp_peak;
    logic [15:0] grp_time_min;
    logic [25:0] grp_weight;
    logic [36:0] grp_moment;

    task automatic report_mismatch(input string what);
        err_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic clear_cluster();
        grp_open     = 1'b0;
        grp_type     = '0;
        grp_count    = '0;
        grp_first    = '0;
        grp_last     = '0;
        grp_amp_sum  = '0;
        grp_amp_peak = '0;
        grp_time_min = 16'hFFFF;
        grp_weight   = '0;
        grp_moment   = '0;
    endtask

    task automatic close_cluster();
        cluster_t c;
        logic [63:0] quot;
        if (grp_open && grp_count >= sh_min_size && grp_count <= sh_max_size)
        begin
            quot = 0;
            if (grp_weight != 0)
            begin
                quot = ({27'd0, grp_moment} << 8) / {38'd0, grp_weight};
                if (quot > {46'd0, CENT_MAX})
                    quot = {46'd0, CENT_MAX};
            end
            c.cluster_type    = grp_type;
            c.cluster_size    = grp_count;
            c.strip_span      = {2'b00, grp_last} + 12'd1 - {2'b00, grp_first};
            c.total_amplitude = grp_amp_sum;
            c.peak_amplitude  = grp_amp_peak;
            c.earliest_time   = grp_time_min;
            c.centroid_q8     = quot[17:0];
            c.last_of_item    = 1'b0;
            pending_clusters.insert(pending_clusters.size(), c);
            push_count++;
        end
        clear_cluster();
    endtask

    task automatic predict_clusters(input hit_t h);
        int n0;
        logic [63:0] s;
        n0 = pending_clusters.size();
        if (h.hit_valid)
        begin
            if (grp_open && (h.strip_type != grp_type ||
                {1'b0, h.strip_number} > {1'b0, grp_last} + 11'd1 + {7'd0, sh_max_gap}))
                close_cluster();
            if (!grp_open)
            begin
                grp_open  = 1'b1;
                grp_type  = h.strip_type;
                grp_first = h.strip_number;
            end
            grp_last = h.strip_number;
            if (grp_count != COUNT_MAX)
                grp_count++;
            s = {38'd0, grp_amp_sum} + {48'd0, h.amplitude};
            grp_amp_sum = (s > {38'd0, SUM26_MAX}) ? SUM26_MAX : s[25:0];
            if (h.amplitude > grp_amp_peak)
                grp_amp_peak = h.amplitude;
            if (h.hit_time < grp_time_min)
                grp_time_min = h.hit_time;
            s = {38'd0, grp_weight} + {48'd0, h.hit_charge};
            grp_weight = (s > {38'd0, SUM26_MAX}) ? SUM26_MAX : s[25:0];
            s = {27'd0, grp_moment} + {54'd0, h.strip_number} * {48'd0, h.hit_charge};
            grp_moment = (s > {27'd0, SUM37_MAX}) ? SUM37_MAX : s[36:0];
        end
        if (h.frame_end)
            close_cluster();
        if (pending_clusters.size() > n0)
            pending_clusters[pending_clusters.size()-1].last_of_item = 1'b1;
    endtask

    // drive one hit beat, hold until taken, then predict
    task automatic send_hit(input hit_t h);
        int gap;
        gap = tx_busy_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_clusters(h);
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        while (pending_clusters.size() != 0)
            @(posedge clk);
        // a rejected cluster never enters the divider; let the block finish its last hit
        repeat (80) @(posedge clk);
    endtask

    task automatic write_config(input logic [3:0] gap, input logic [10:0] mn,
                                input logic [10:0] mx);
        cfg_we <= 1'b1; cfg_index <= REG_MAX_GAP; cfg_data <= {7'd0, gap};
        @(posedge clk);
        cfg_index <= REG_MIN_SIZE; cfg_data <= mn;
        @(posedge clk);
        cfg_index <= REG_MAX_SIZE; cfg_data <= mx;
        @(posedge clk);
        cfg_we <= 1'b0;
        sh_max_gap  = gap;
        sh_min_size = mn;
        sh_max_size = mx;
    endtask

    // receiver: check each report beat, stall at random between beats
    int rx_stall = 0;
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_clusters.size() == 0)
                report_mismatch("cluster report with none expected");
            else
            begin
                cluster_t e;
                e = pending_clusters.pop_front();
                if (out_data.cluster_type !== e.cluster_type)
                    report_mismatch($sformatf("type %0d exp %0d",
                        out_data.cluster_type, e.cluster_type));
                if (out_data.cluster_size !== e.cluster_size)
                    report_mismatch($sformatf("size %0d exp %0d",
                        out_data.cluster_size, e.cluster_size));
                if (out_data.strip_span !== e.strip_span)
                    report_mismatch($sformatf("span %0d exp %0d",
                        out_data.strip_span, e.strip_span));
                if (out_data.total_amplitude !== e.total_amplitude)
                    report_mismatch($sformatf("amp sum %0d exp %0d",
                        out_data.total_amplitude, e.total_amplitude));
                if (out_data.peak_amplitude !== e.peak_amplitude)
                    report_mismatch($sformatf("peak %0d exp %0d",
                        out_data.peak_amplitude, e.peak_amplitude));
                if (out_data.earliest_time !== e.earliest_time)
                    report_mismatch($sformatf("time %0d exp %0d",
                        out_data.earliest_time, e.earliest_time));
                if (out_data.centroid_q8 !== e.centroid_q8)
                    report_mismatch($sformatf("centroid %0d exp %0d",
                        out_data.centroid_q8, e.centroid_q8));
                if (out_data.last_of_item !== e.last_of_item)
                    report_mismatch($sformatf("last flag %0b exp %0b",
                        out_data.last_of_item, e.last_of_item));
            end
            rx_stall = rx_busy_mode ? 0 : $urandom_range(0, 15);
            out_ready <= (rx_stall == 0);
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            out_ready <= (rx_stall == 0);
        end
        else
            out_ready <= 1'b1;
    end

    typedef struct {
        hit_t     h;
        bit       has_exp;
        cluster_t e;
    } hit_row_t;

    function automatic hit_t mk_hit(bit v, int ty, int st, int amp, int ch, int tm, bit fe);
        hit_t h;
        h.hit_valid    = v;
        h.strip_type   = ty[1:0];
        h.strip_number = st[9:0];
        h.amplitude    = amp[15:0];
        h.hit_charge   = ch[15:0];
        h.hit_time     = tm[15:0];
        h.frame_end    = fe;
        return h;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    hit_row_t dir_rows[$];
    int       cur_strip;
    int       cur_type;

    task automatic add_row(input hit_t h, input bit has_exp, input cluster_t e);
        hit_row_t r;
        r.h       = h;
        r.has_exp = has_exp;
        r.e       = e;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic random_phase(input int count);
        hit_t        h;
        int          r;
        logic [63:0] raw;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                tx_busy_mode = ($urandom_range(0, 3) == 0);
                rx_busy_mode = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                raw = {$urandom, $urandom};
                h = raw[$bits(hit_t)-1:0];
            end
            else
            begin
                // well-formed stream: mostly neighbours of the same plane
                if ($urandom_range(0, 9) == 0)
                    cur_type = $urandom_range(0, 3);
                if ($urandom_range(0, 7) == 0)
                    cur_strip = $urandom_range(0, 1023);
                else
                    cur_strip = (cur_strip + $urandom_range(0, sh_max_gap + 2)) % 1024;
                h = mk_hit(r >= 20, cur_type, cur_strip, rand_sample(), rand_sample(),
                           rand_sample(), $urandom_range(0, 14) == 0);
            end
            send_hit(h);
        end
    endtask

    initial
    begin
        cluster_t e;
        sh_max_gap  = 4'd0;
        sh_min_size = 11'd1;
        sh_max_size = 11'd1024;
        clear_cluster();
        cur_strip = 0;
        cur_type  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single hit at the low extremes, zero charge gives centroid 0
        e = '{2'd0, 11'd1, 12'sd1, 26'hFFFF, 16'hFFFF, 16'd0, 18'd0, 1'b1};
        add_row(mk_hit(1, 0, 0, 16'hFFFF, 0, 0, 1), 1, e);
        // single hit at the top strip and type
        e = '{2'd3, 11'd1, 12'sd1, 26'd0, 16'd0, 16'hFFFF, 18'h3FF00, 1'b1};
        add_row(mk_hit(1, 3, 1023, 0, 16'hFFFF, 16'hFFFF, 1), 1, e);
        // frame end on an empty group
        add_row(mk_hit(0, 2, 5, 7, 7, 7, 1), 0, e);
        add_row(mk_hit(1, 1, 10, 100, 50, 30, 0), 0, e);
        add_row(mk_hit(1, 1, 11, 200, 70, 20, 0), 0, e);
        add_row(mk_hit(1, 1, 13, 50, 90, 40, 0), 0, e);
        add_row(mk_hit(1, 2, 13, 10, 10, 10, 0), 0, e);
        add_row(mk_hit(1, 2, 5, 20, 30, 5, 0), 0, e);
        add_row(mk_hit(1, 2, 3, 20, 30, 5, 0), 0, e);
        // invalid hit still flushes; span goes negative
        add_row(mk_hit(0, 0, 0, 0, 0, 0, 1), 0, e);
        add_row(mk_hit(1, 0, 100, 1, 2, 3, 0), 0, e);
        // break and flush on one hit
        add_row(mk_hit(1, 0, 200, 4, 5, 6, 1), 0, e);
        add_row(mk_hit(1, 3, 512, 16'hFFFF, 16'hFFFF, 0, 0), 0, e);
        add_row(mk_hit(1, 3, 512, 16'hFFFF, 16'hFFFF, 0, 1), 0, e);

        foreach (dir_rows[i])
        begin
            int n0;
            n0 = push_count;
            send_hit(dir_rows[i].h);
            if (dir_rows[i].has_exp &&
                (push_count != n0 + 1 ||
                 pending_clusters[pending_clusters.size()-1] !== dir_rows[i].e))
                report_mismatch($sformatf("row %0d predicted report differs", i));
        end
        random_phase(250);
        drain_reports();

        write_config(4'd15, 11'd0, 11'd1024);
        random_phase(280);
        drain_reports();
        write_config(4'd0, 11'd1, 11'd1);
        random_phase(250);
        drain_reports();
        write_config(4'd3, 11'd2, 11'd4);
        random_phase(300);
        drain_reports();
        write_config(4'd7, 11'd0, 11'd0);
        random_phase(120);
        drain_reports();
        write_config(4'd5, 11'd1, 11'd1024);
        random_phase(280);
        drain_reports();
        write_config(4'd15, 11'd3, 11'd1024);
        random_phase(250);

        drain_reports();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
